// ----- hw/rtl/lmsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lmsc_pkg
// Shared types and codes of the LED matrix scroll controller: payload
// structs, register map, operation and button codes, controller interface.
// ----------------------------------------------------------------------------
package lmsc_pkg;

  localparam int ROW_COUNT  = 8;
  localparam int CFG_DATA_W = 10;
  localparam int PIXEL_W    = 32;
  localparam logic [8:0] STEP_WRAP = 9'd500;

  // Input item: one transaction on the item channel
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] column_address;
    logic [7:0] column_byte;
    logic [2:0] button;
  } item_t;

  // Result item: one row of the display
  typedef struct packed {
    logic [2:0]         row_index;
    logic               row_enable;
    logic [PIXEL_W-1:0] row_pixels;
    logic               frame_start;
  } result_t;

  // Operation codes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_BUTTON = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Button codes
  localparam logic [2:0] BTN_STATIC = 3'd0;
  localparam logic [2:0] BTN_UP     = 3'd1;
  localparam logic [2:0] BTN_DOWN   = 3'd2;
  localparam logic [2:0] BTN_BLINK  = 3'd3;
  localparam logic [2:0] BTN_CONT1  = 3'd4;
  localparam logic [2:0] BTN_CONT2  = 3'd5;

  // Display modes
  localparam logic [1:0] MODE_STATIC = 2'd0;
  localparam logic [1:0] MODE_UP     = 2'd1;
  localparam logic [1:0] MODE_DOWN   = 2'd2;
  localparam logic [1:0] MODE_BLINK  = 2'd3;

  // Scroll directions
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_C1_FIRST   = 3'd0;
  localparam logic [2:0] REG_C1_LAST    = 3'd1;
  localparam logic [2:0] REG_C2_FIRST   = 3'd2;
  localparam logic [2:0] REG_C2_LAST    = 3'd3;
  localparam logic [2:0] REG_FRAMES     = 3'd4;
  localparam logic [2:0] REG_TICKS      = 3'd5;
  localparam logic [2:0] REG_BLINK_N    = 3'd6;
  localparam logic [2:0] REG_BLINK_DARK = 3'd7;

  // Configuration register file contents
  typedef struct packed {
    logic [7:0] content_one_first;
    logic [7:0] content_one_last;
    logic [7:0] content_two_first;
    logic [7:0] content_two_last;
    logic [7:0] frames_per_step;
    logic [7:0] ticks_per_row;
    logic [3:0] blink_every;
    logic [9:0] blink_dark_ticks;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;        // item transaction this cycle
    logic start_sweep; // latch mode and bounds, pick first window start
    logic mod_init;    // clear the blink remainder unit
    logic mod_step;    // one remainder step
    logic begin_step;  // set up a scroll step and the window fill
    logic fill_run;    // window fill in progress
    logic emit;        // load the result register and advance the scan
    logic advance;     // move the window one column, or end the sweep
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sweep_on;
    logic start_ok;
    logic mod_last;
    logic fill_done;
    logic out_free;
    logic need_advance;
    logic adv_continue;
  } status_t;

endpackage

// ----- hw/rtl/lmsc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lmsc_cfg_regs
// Configuration register file: write-only, indexed, values masked to width.
// ----------------------------------------------------------------------------
module lmsc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [lmsc_pkg::CFG_DATA_W-1:0] cfg_data,
  output lmsc_pkg::cfg_t                cfg
);
  import lmsc_pkg::*;

  // Load reset defaults, then take writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.content_one_first <= 8'd0;
      cfg.content_one_last  <= 8'd63;
      cfg.content_two_first <= 8'd64;
      cfg.content_two_last  <= 8'd208;
      cfg.frames_per_step   <= 8'd10;
      cfg.ticks_per_row     <= 8'd5;
      cfg.blink_every       <= 4'd5;
      cfg.blink_dark_ticks  <= 10'd500;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_C1_FIRST:   cfg.content_one_first <= cfg_data[7:0];
        REG_C1_LAST:    cfg.content_one_last  <= cfg_data[7:0];
        REG_C2_FIRST:   cfg.content_two_first <= cfg_data[7:0];
        REG_C2_LAST:    cfg.content_two_last  <= cfg_data[7:0];
        REG_FRAMES:     cfg.frames_per_step   <= cfg_data[7:0];
        REG_TICKS:      cfg.ticks_per_row     <= cfg_data[7:0];
        REG_BLINK_N:    cfg.blink_every       <= cfg_data[3:0];
        REG_BLINK_DARK: cfg.blink_dark_ticks  <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/lmsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lmsc_ctrl
// Sequencer: takes items, runs sweep start, blink remainder, window fill,
// result emission and window advance through the datapath.
// ----------------------------------------------------------------------------
module lmsc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic [1:0]          operation,
  output logic                item_stall,
  input  lmsc_pkg::status_t   status,
  output lmsc_pkg::cmd_t      cmd
);
  import lmsc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_STEP  = 7'b0001000,
    S_FILL  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_ADV   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   pend, pend_next;   // a tick waits for its result after the fill

  assign item_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    pend_next  = pend;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.take = 1'b1;
          if (operation == OP_TICK) begin
            state_next = status.sweep_on ? S_EMIT : S_START;
          end
        end
      end
      S_START: begin
        cmd.start_sweep = 1'b1;
        cmd.mod_init    = 1'b1;
        if (status.start_ok) begin
          pend_next  = 1'b1;
          state_next = S_MOD;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.begin_step = 1'b1;
        state_next     = S_FILL;
      end
      S_FILL: begin
        cmd.fill_run = 1'b1;
        if (status.fill_done) begin
          pend_next  = 1'b0;
          state_next = pend ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.need_advance ? S_ADV : S_IDLE;
        end
      end
      S_ADV: begin
        cmd.advance  = 1'b1;
        cmd.mod_init = 1'b1;
        state_next   = status.adv_continue ? S_MOD : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

endmodule

// ----- hw/rtl/lmsc_datapath.sv -----
// ----------------------------------------------------------------------------
// lmsc_datapath
// Column memory, window buffer, mode and scan registers, blink remainder
// unit and the result register.
// ----------------------------------------------------------------------------
module lmsc_datapath #(
  parameter int COLUMN_DEPTH = 256,
  parameter int WINDOW_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  lmsc_pkg::cfg_t      cfg,
  input  lmsc_pkg::item_t     item,
  input  lmsc_pkg::cmd_t      cmd,
  output lmsc_pkg::status_t   status,
  output logic                result_valid,
  input  logic                result_stall,
  output lmsc_pkg::result_t   result
);
  import lmsc_pkg::*;

  // Depth is taken as a power of two, so address wrap is a truncation
  localparam int AW   = $clog2(COLUMN_DEPTH);
  localparam int WIW  = $clog2(WINDOW_WIDTH);
  localparam int CW   = $clog2(WINDOW_WIDTH + 1);
  localparam int SW   = AW + 9;
  localparam int NPIX = (WINDOW_WIDTH < PIXEL_W) ? WINDOW_WIDTH : PIXEL_W;
  localparam logic [CW-1:0] FILL_LAST = CW'(WINDOW_WIDTH);

  // Column memory
  logic [7:0]    mem [COLUMN_DEPTH];
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    rd_data;
  logic          mem_we;

  // Window buffer and fill pipeline
  logic [7:0]     wbuf [WINDOW_WIDTH];
  logic [CW-1:0]  fill_cnt;
  logic [7:0]     fill_base;
  logic           fill_wr;
  logic [WIW-1:0] fill_idx;
  logic [SW-1:0]  fill_sum;
  logic [SW-1:0]  addr_ext;

  // Mode, sweep and scan state
  logic [1:0] display_mode, scroll_direction, run_mode, run_dir;
  logic       content_choice, sweep_on;
  logic [7:0] lo_bound, hi_bound, window_start;
  logic [7:0] frame_count, row_tick_count;
  logic [2:0] scan_row;
  logic [8:0] step_count;
  logic [9:0] dark_count;

  // Blink remainder unit
  logic [3:0] rem;
  logic [3:0] rem_idx;
  logic [4:0] rem_sh, period;

  // Sweep start decisions
  logic [1:0] st_mode, st_dir;
  logic [7:0] st_lo, st_hi;
  logic       st_ok;

  // Scan arithmetic
  logic [7:0]         tpr_eff, fps_eff, rtc_inc, fc_inc, ws_next;
  logic               rtc_wrap, frame_wrap, lit, adv_end, blink_now;
  logic [PIXEL_W-1:0] pixels;
  result_t            res_next;

  assign mem_we   = cmd.take && (item.operation == OP_WRITE);
  assign addr_ext = SW'(item.column_address);
  assign wr_addr  = addr_ext[AW-1:0];
  assign fill_sum = SW'(fill_base) + SW'(fill_cnt);
  assign rd_addr  = fill_sum[AW-1:0];

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= item.column_byte;
    end
    rd_data <= mem[rd_addr];
  end

  // Sweep start: latch mode and bounds of the chosen content
  always_comb begin
    st_mode = display_mode;
    st_lo   = content_choice ? cfg.content_two_first : cfg.content_one_first;
    st_hi   = content_choice ? cfg.content_two_last  : cfg.content_one_last;
    st_dir  = (st_mode == MODE_BLINK) ? scroll_direction : st_mode;
    if (st_mode == MODE_STATIC) begin
      st_ok = 1'b1;
    end else if (st_dir == DIR_UP) begin
      st_ok = (st_lo < st_hi);
    end else if (st_dir == DIR_DOWN) begin
      st_ok = (st_hi > st_lo);
    end else begin
      st_ok = 1'b0;
    end
  end

  // Scan arithmetic, zero timing values act as one
  always_comb begin
    tpr_eff    = (cfg.ticks_per_row == 8'd0) ? 8'd1 : cfg.ticks_per_row;
    fps_eff    = (run_mode == MODE_STATIC) ? 8'd1 :
                 ((cfg.frames_per_step == 8'd0) ? 8'd1 : cfg.frames_per_step);
    rtc_inc    = row_tick_count + 8'd1;
    fc_inc     = frame_count + 8'd1;
    rtc_wrap   = (rtc_inc >= tpr_eff);
    frame_wrap = (fc_inc >= fps_eff);
    lit        = sweep_on && (dark_count == 10'd0);
    ws_next    = (run_dir == DIR_UP) ? (window_start + 8'd1) : (window_start - 8'd1);
    adv_end    = (run_dir == DIR_UP) ? (ws_next >= hi_bound) : (ws_next <= lo_bound);
    period     = (cfg.blink_every == 4'd0) ? 5'd1 : {1'b0, cfg.blink_every};
    rem_sh     = {rem, step_count[rem_idx]};
    blink_now  = (run_mode == MODE_BLINK) && (rem == 4'd0);
  end

  // Gather one row of pixels, bit 7 of a column is row 0
  always_comb begin
    pixels = '0;
    for (int j = 0; j < NPIX; j++) begin
      pixels[j] = wbuf[j][~scan_row];
    end
  end

  always_comb begin
    res_next.row_index   = scan_row;
    res_next.row_enable  = lit;
    res_next.row_pixels  = lit ? pixels : '0;
    res_next.frame_start = lit && (scan_row == 3'd0) && (row_tick_count == 8'd0);
  end

  assign status.sweep_on     = sweep_on;
  assign status.start_ok     = st_ok;
  assign status.mod_last     = (rem_idx == 4'd0);
  assign status.fill_done    = (fill_cnt == FILL_LAST);
  assign status.out_free     = !result_valid || !result_stall;
  assign status.need_advance = lit && rtc_wrap && (scan_row == 3'(ROW_COUNT - 1)) &&
                               frame_wrap;
  assign status.adv_continue = (run_mode != MODE_STATIC) && !adv_end;

  // Control and scan registers
  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode     <= MODE_STATIC;
      scroll_direction <= DIR_NONE;
      content_choice   <= 1'b0;
      sweep_on         <= 1'b0;
      run_mode         <= MODE_STATIC;
      run_dir          <= DIR_NONE;
      lo_bound         <= 8'd0;
      hi_bound         <= 8'd0;
      window_start     <= 8'd0;
      frame_count      <= 8'd0;
      row_tick_count   <= 8'd0;
      scan_row         <= 3'd0;
      step_count       <= 9'd0;
      dark_count       <= 10'd0;
      rem              <= 4'd0;
      rem_idx          <= 4'd0;
      fill_cnt         <= '0;
      fill_base        <= 8'd0;
      fill_wr          <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      // Button transactions
      if (cmd.take && (item.operation == OP_BUTTON)) begin
        case (item.button)
          BTN_STATIC: display_mode <= MODE_STATIC;
          BTN_UP: begin
            display_mode     <= MODE_UP;
            scroll_direction <= DIR_UP;
          end
          BTN_DOWN: begin
            display_mode     <= MODE_DOWN;
            scroll_direction <= DIR_DOWN;
          end
          BTN_BLINK: display_mode   <= MODE_BLINK;
          BTN_CONT1: content_choice <= 1'b0;
          BTN_CONT2: content_choice <= 1'b1;
          default: begin
          end
        endcase
      end

      // Start a sweep
      if (cmd.start_sweep) begin
        run_mode <= st_mode;
        run_dir  <= (st_mode == MODE_STATIC) ? DIR_NONE : st_dir;
        lo_bound <= st_lo;
        hi_bound <= st_hi;
        sweep_on <= st_ok;
        if (st_mode == MODE_STATIC) begin
          content_choice <= 1'b0;
          window_start   <= 8'(WINDOW_WIDTH);
        end else if (st_ok) begin
          window_start <= (st_dir == DIR_UP) ? st_lo : st_hi;
        end
      end

      // Remainder of step count by the blink period, one bit a cycle
      if (cmd.mod_init) begin
        rem     <= 4'd0;
        rem_idx <= 4'd8;
      end else if (cmd.mod_step) begin
        rem     <= (rem_sh >= period) ? 4'(rem_sh - period) : rem_sh[3:0];
        rem_idx <= rem_idx - 4'd1;
      end

      // Set up a scroll step
      if (cmd.begin_step) begin
        fill_base      <= blink_now ? 8'd0 : window_start;
        dark_count     <= blink_now ? cfg.blink_dark_ticks : 10'd0;
        if (run_mode == MODE_BLINK) begin
          step_count <= (step_count < STEP_WRAP) ? (step_count + 9'd1) : 9'd0;
        end
        frame_count    <= 8'd0;
        scan_row       <= 3'd0;
        row_tick_count <= 8'd0;
        fill_cnt       <= '0;
      end

      // Advance the fill counter; the buffer write comes in the cycle after its read
      fill_wr <= 1'b0;
      if (cmd.fill_run && (fill_cnt != FILL_LAST)) begin
        fill_cnt <= fill_cnt + CW'(1);
        fill_wr  <= 1'b1;
      end

      // Result register: load on emit, drop once taken
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      // Advance the scan on a tick
      if (cmd.emit && sweep_on) begin
        if (dark_count != 10'd0) begin
          dark_count <= dark_count - 10'd1;
        end else if (rtc_wrap) begin
          row_tick_count <= 8'd0;
          if (scan_row == 3'(ROW_COUNT - 1)) begin
            scan_row    <= 3'd0;
            frame_count <= frame_wrap ? 8'd0 : fc_inc;
          end else begin
            scan_row <= scan_row + 3'd1;
          end
        end else begin
          row_tick_count <= rtc_inc;
        end
      end

      // Move the window one column, or end the sweep
      if (cmd.advance) begin
        if (run_mode == MODE_STATIC) begin
          sweep_on <= 1'b0;
        end else begin
          window_start <= ws_next;
          if (adv_end) begin
            sweep_on <= 1'b0;
          end
        end
      end
    end
  end

  // Fill index follows the read address in the next cycle
  always_ff @(posedge clk) begin
    fill_idx <= fill_cnt[WIW-1:0];
    if (cmd.emit) begin
      result <= res_next;
    end
  end

  // Window buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < WINDOW_WIDTH; j++) begin
        wbuf[j] <= 8'd0;
      end
    end else if (fill_wr) begin
      wbuf[fill_idx] <= rd_data;
    end
  end

endmodule

// ----- hw/rtl/led_matrix_scroll_controller_top.sv -----
// ----------------------------------------------------------------------------
// led_matrix_scroll_controller_top
// Marquee driver for an 8-row multiplexed LED matrix fed from a column
// memory; gives one row of pixels per tick.
//
//   Channel  Signals                          Direction  Content
//   item     item_valid, item_stall, item     in         write, button, tick
//   result   result_valid, result_stall,      out        one display row
//            result
//   config   cfg_we, cfg_index, cfg_data      in         register writes
//
// Column writes and button events are taken in the idle state. A tick inside
// a running step goes straight to its result. A tick that starts a sweep with
// valid bounds, or that ends a step the sweep goes on past, adds a blink
// remainder pass and a window fill through the single memory read port.
// Reset is synchronous and clears all control state; no sweep runs after it.
// A stalled result holds in its register while the next item is taken.
// ----------------------------------------------------------------------------
module led_matrix_scroll_controller_top #(
  parameter int COLUMN_DEPTH = 256,
  parameter int WINDOW_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  lmsc_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output lmsc_pkg::result_t               result,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [lmsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lmsc_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  lmsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lmsc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .operation  (item.operation),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  lmsc_datapath #(
    .COLUMN_DEPTH (COLUMN_DEPTH),
    .WINDOW_WIDTH (WINDOW_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
